/* hdl/time_of_day_adjust_defines.svh */
// Assertion macros used by the time of day adjust checker.
`ifndef TIME_OF_DAY_ADJUST_DEFINES_SVH
`define TIME_OF_DAY_ADJUST_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define TDA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define TDA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/tda_pkg.sv */
// Types, codes and constants of the time of day adjust block.
package tda_pkg;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] amount;
    logic [7:0]  load_hours;
    logic [7:0]  load_minutes;
    logic [7:0]  load_seconds;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  cur_hours;
    logic [5:0]  cur_minutes;
    logic [5:0]  cur_seconds;
    logic [16:0] day_seconds;
    logic [2:0]  status;
  } out_item_t;

  localparam logic [2:0] OP_LOAD    = 3'd0;
  localparam logic [2:0] OP_ADD_SEC = 3'd1;
  localparam logic [2:0] OP_ADD_MIN = 3'd2;
  localparam logic [2:0] OP_ADD_HR  = 3'd3;
  localparam logic [2:0] OP_SUB_SEC = 3'd4;
  localparam logic [2:0] OP_SUB_MIN = 3'd5;
  localparam logic [2:0] OP_SUB_HR  = 3'd6;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_BAD_HOURS   = 3'd1;
  localparam logic [2:0] ST_BAD_MINUTES = 3'd2;
  localparam logic [2:0] ST_BAD_SECONDS = 3'd3;
  localparam logic [2:0] ST_ZERO_AMOUNT = 3'd4;

  localparam logic [7:0] LOAD_HOURS_LIMIT = 8'd24;
  localparam logic [7:0] LOAD_UNIT_LIMIT  = 8'd60;

  localparam logic [5:0]  SECS_PER_MIN    = 6'd60;
  localparam logic [5:0]  MINS_PER_HOUR   = 6'd60;
  localparam logic [4:0]  HOURS_PER_DAY   = 5'd24;
  localparam logic [16:0] DAY_SECS_PER_MIN  = 17'd60;
  localparam logic [16:0] DAY_SECS_PER_HOUR = 17'd3600;

  // ceil(2^34 / 15) and ceil(2^31 / 3): exact quotients for 30 and 29 bit dividends.
  localparam logic [30:0] RECIP_15 = 31'd1145324613;
  localparam logic [29:0] RECIP_3  = 30'd715827883;

  typedef enum logic [1:0] {
    KIND_HOLD = 2'd0,
    KIND_LOAD = 2'd1,
    KIND_ADD  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    UNIT_SEC = 2'd0,
    UNIT_MIN = 2'd1,
    UNIT_HR  = 2'd2
  } unit_t;

  typedef struct packed {
    kind_t      kind;
    unit_t      unit;
    logic       sub;
    logic [2:0] status;
    logic [4:0] ld_h;
    logic [5:0] ld_m;
    logic [5:0] ld_s;
  } ctx_t;

  typedef struct packed {
    kind_t      kind;
    logic [4:0] dh;
    logic [5:0] dm;
    logic [5:0] ds;
    logic [2:0] status;
  } step_t;

endpackage

/* hdl/time_of_day_adjust.sv */
// Top level of the time of day adjust block.
// A beat passes the input register, the split stages and the result stage, where
// the time registers update; the rate is one beat per cycle while out_stall is low.
// Synchronous active-low reset clears the time to midnight and empties the pipeline.
// Payload registers are not reset.
module time_of_day_adjust
  import tda_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic  in_ready;
  logic  step_valid;
  logic  step_ready;
  step_t step;

  assign in_stall = !in_ready;

  tda_split u_split (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .in_ready   (in_ready),
    .step_valid (step_valid),
    .step       (step),
    .step_ready (step_ready)
  );

  tda_clock u_clock (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_valid (step_valid),
    .step       (step),
    .step_ready (step_ready),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .out_stall  (out_stall)
  );

endmodule

/* hdl/tda_split.sv */
// Input register and pipeline that turns a command into an hours, minutes, seconds step.
module tda_split
  import tda_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  in_item_t in_data,
  output logic     in_ready,
  output logic     step_valid,
  output step_t    step,
  input  logic     step_ready
);

  in_item_t    in_r;
  logic        in_vld_r;

  ctx_t        a_ctx_r;
  logic [26:0] a_q_r;
  logic [5:0]  a_lo_r;
  logic [31:0] a_amt_r;
  logic        a_vld_r;

  ctx_t        b_ctx_r;
  logic [5:0]  b_s_r;
  logic [26:0] b_q_r;
  logic [5:0]  b_lo_r;
  logic [31:0] b_amt_r;
  logic        b_vld_r;

  ctx_t        c_ctx_r;
  logic [5:0]  c_s_r;
  logic [5:0]  c_m_r;
  logic [27:0] c_q_r;
  logic [4:0]  c_lo_r;
  logic        c_vld_r;

  step_t       d_step_r;
  logic        d_vld_r;

  logic        i_rdy;
  logic        a_rdy;
  logic        b_rdy;
  logic        c_rdy;
  logic        d_rdy;

  ctx_t        a_ctx_nxt;
  logic [60:0] a_prod;
  logic [31:0] b_n;
  logic [5:0]  b_s_nxt;
  logic [60:0] b_prod;
  logic [31:0] c_n;
  logic [5:0]  c_m_nxt;
  logic [58:0] c_prod;
  logic [4:0]  d_h;
  logic [5:0]  neg_s;
  logic [6:0]  neg_tm;
  logic [5:0]  neg_m;
  logic [5:0]  neg_th;
  logic [4:0]  neg_h;
  step_t       d_step_nxt;

  assign d_rdy = !d_vld_r || step_ready;
  assign c_rdy = !c_vld_r || d_rdy;
  assign b_rdy = !b_vld_r || c_rdy;
  assign a_rdy = !a_vld_r || b_rdy;
  assign i_rdy = !in_vld_r || a_rdy;

  assign in_ready   = i_rdy;
  assign step_valid = d_vld_r;
  assign step       = d_step_r;

  // Decode the command, check load fields and turn a zero amount into a hold.
  always_comb begin
    a_ctx_nxt.kind   = KIND_HOLD;
    a_ctx_nxt.unit   = UNIT_SEC;
    a_ctx_nxt.sub    = (in_r.op >= OP_SUB_SEC);
    a_ctx_nxt.status = ST_OK;
    a_ctx_nxt.ld_h   = '0;
    a_ctx_nxt.ld_m   = '0;
    a_ctx_nxt.ld_s   = '0;
    unique case (in_r.op) inside
      OP_LOAD: begin
        a_ctx_nxt.kind = KIND_LOAD;
        if (in_r.load_hours >= LOAD_HOURS_LIMIT) begin
          a_ctx_nxt.status = ST_BAD_HOURS;
        end else if (in_r.load_minutes >= LOAD_UNIT_LIMIT) begin
          a_ctx_nxt.status = ST_BAD_MINUTES;
        end else if (in_r.load_seconds >= LOAD_UNIT_LIMIT) begin
          a_ctx_nxt.status = ST_BAD_SECONDS;
        end else begin
          a_ctx_nxt.ld_h = in_r.load_hours[4:0];
          a_ctx_nxt.ld_m = in_r.load_minutes[5:0];
          a_ctx_nxt.ld_s = in_r.load_seconds[5:0];
        end
      end
      OP_ADD_SEC, OP_SUB_SEC: begin
        a_ctx_nxt.unit = UNIT_SEC;
        a_ctx_nxt.kind = KIND_ADD;
      end
      OP_ADD_MIN, OP_SUB_MIN: begin
        a_ctx_nxt.unit = UNIT_MIN;
        a_ctx_nxt.kind = KIND_ADD;
      end
      OP_ADD_HR, OP_SUB_HR: begin
        a_ctx_nxt.unit = UNIT_HR;
        a_ctx_nxt.kind = KIND_ADD;
      end
      default: begin
        a_ctx_nxt.kind = KIND_HOLD;
      end
    endcase
    if (a_ctx_nxt.kind == KIND_ADD && in_r.amount == '0) begin
      a_ctx_nxt.kind   = KIND_HOLD;
      a_ctx_nxt.status = ST_ZERO_AMOUNT;
    end
  end

  // Seconds are split by 60, 60 and 24, minutes by 60 and 24, hours by 24; each quotient
  // comes from a reciprocal product and each remainder from the low bits alone.
  assign a_prod = 61'(in_r.amount[31:2]) * 61'(RECIP_15);

  always_comb begin
    if (a_ctx_r.unit == UNIT_SEC) begin
      b_n     = {5'd0, a_q_r};
      b_s_nxt = 6'(a_lo_r + {a_q_r[3:0], 2'b00});
    end else begin
      b_n     = a_amt_r;
      b_s_nxt = '0;
    end
  end

  assign b_prod = 61'(b_n[31:2]) * 61'(RECIP_15);

  always_comb begin
    if (b_ctx_r.unit == UNIT_HR) begin
      c_n     = b_amt_r;
      c_m_nxt = '0;
    end else begin
      c_n     = {5'd0, b_q_r};
      c_m_nxt = 6'(b_lo_r + {b_q_r[3:0], 2'b00});
    end
  end

  assign c_prod = 59'(c_n[31:3]) * 59'(RECIP_3);

  // A subtraction becomes an addition of the step's complement within one day.
  always_comb begin
    d_h    = 5'(c_lo_r + {c_q_r[1:0], 3'b000});
    neg_s  = (c_s_r == '0) ? 6'd0 : 6'(SECS_PER_MIN - c_s_r);
    neg_tm = 7'(c_m_r) + 7'(c_s_r != '0);
    neg_m  = (neg_tm == '0) ? 6'd0 : 6'(7'(MINS_PER_HOUR) - neg_tm);
    neg_th = 6'(d_h) + 6'(neg_tm != '0);
    neg_h  = (neg_th == '0) ? 5'd0 : 5'(6'(HOURS_PER_DAY) - neg_th);

    d_step_nxt.kind   = c_ctx_r.kind;
    d_step_nxt.status = c_ctx_r.status;
    if (c_ctx_r.kind == KIND_LOAD) begin
      d_step_nxt.dh = c_ctx_r.ld_h;
      d_step_nxt.dm = c_ctx_r.ld_m;
      d_step_nxt.ds = c_ctx_r.ld_s;
    end else if (c_ctx_r.sub) begin
      d_step_nxt.dh = neg_h;
      d_step_nxt.dm = neg_m;
      d_step_nxt.ds = neg_s;
    end else begin
      d_step_nxt.dh = d_h;
      d_step_nxt.dm = c_m_r;
      d_step_nxt.ds = c_s_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      a_vld_r  <= 1'b0;
      b_vld_r  <= 1'b0;
      c_vld_r  <= 1'b0;
      d_vld_r  <= 1'b0;
    end else begin
      if (i_rdy) begin
        in_vld_r <= in_valid;
      end
      if (a_rdy) begin
        a_vld_r <= in_vld_r;
      end
      if (b_rdy) begin
        b_vld_r <= a_vld_r;
      end
      if (c_rdy) begin
        c_vld_r <= b_vld_r;
      end
      if (d_rdy) begin
        d_vld_r <= c_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (i_rdy && in_valid) begin
      in_r <= in_data;
    end
    if (a_rdy && in_vld_r) begin
      a_ctx_r <= a_ctx_nxt;
      a_q_r   <= a_prod[60:34];
      a_lo_r  <= in_r.amount[5:0];
      a_amt_r <= in_r.amount;
    end
    if (b_rdy && a_vld_r) begin
      b_ctx_r <= a_ctx_r;
      b_s_r   <= b_s_nxt;
      b_q_r   <= b_prod[60:34];
      b_lo_r  <= b_n[5:0];
      b_amt_r <= a_amt_r;
    end
    if (c_rdy && b_vld_r) begin
      c_ctx_r <= b_ctx_r;
      c_s_r   <= b_s_r;
      c_m_r   <= c_m_nxt;
      c_q_r   <= c_prod[58:31];
      c_lo_r  <= c_n[4:0];
    end
    if (d_rdy && c_vld_r) begin
      d_step_r <= d_step_nxt;
    end
  end

endmodule

/* hdl/tda_clock.sv */
// Time of day registers, carry into higher units and the result register.
module tda_clock
  import tda_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step_valid,
  input  step_t     step,
  output logic      step_ready,
  output logic      out_valid,
  output out_item_t out_data,
  input  logic      out_stall
);

  logic [4:0] hr_r;
  logic [5:0] min_r;
  logic [5:0] sec_r;
  logic       out_vld_r;
  out_item_t  out_r;

  logic [4:0]  hr_nxt;
  logic [5:0]  min_nxt;
  logic [5:0]  sec_nxt;
  out_item_t   out_nxt;
  logic [6:0]  s_sum;
  logic [6:0]  m_sum;
  logic [5:0]  h_sum;
  logic        s_carry;
  logic        m_carry;
  logic [5:0]  s_wrap;
  logic [5:0]  m_wrap;
  logic [4:0]  h_wrap;
  logic        take;

  assign step_ready = !out_vld_r || !out_stall;
  assign take       = step_valid && step_ready;
  assign out_valid  = out_vld_r;
  assign out_data   = out_r;

  always_comb begin
    s_sum   = 7'(sec_r) + 7'(step.ds);
    s_carry = (s_sum >= 7'(SECS_PER_MIN));
    s_wrap  = s_carry ? 6'(s_sum - 7'(SECS_PER_MIN)) : s_sum[5:0];
    m_sum   = 7'(min_r) + 7'(step.dm) + 7'(s_carry);
    m_carry = (m_sum >= 7'(MINS_PER_HOUR));
    m_wrap  = m_carry ? 6'(m_sum - 7'(MINS_PER_HOUR)) : m_sum[5:0];
    h_sum   = 6'(hr_r) + 6'(step.dh) + 6'(m_carry);
    h_wrap  = (h_sum >= 6'(HOURS_PER_DAY)) ? 5'(h_sum - 6'(HOURS_PER_DAY)) : h_sum[4:0];

    unique case (step.kind)
      KIND_ADD: begin
        hr_nxt  = h_wrap;
        min_nxt = m_wrap;
        sec_nxt = s_wrap;
      end
      KIND_LOAD: begin
        hr_nxt  = step.dh;
        min_nxt = step.dm;
        sec_nxt = step.ds;
      end
      default: begin
        hr_nxt  = hr_r;
        min_nxt = min_r;
        sec_nxt = sec_r;
      end
    endcase

    out_nxt.cur_hours   = hr_nxt;
    out_nxt.cur_minutes = min_nxt;
    out_nxt.cur_seconds = sec_nxt;
    out_nxt.day_seconds = 17'(17'(hr_nxt) * DAY_SECS_PER_HOUR)
                        + 17'(17'(min_nxt) * DAY_SECS_PER_MIN)
                        + 17'(sec_nxt);
    out_nxt.status      = step.status;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hr_r      <= '0;
      min_r     <= '0;
      sec_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (take) begin
        hr_r      <= hr_nxt;
        min_r     <= min_nxt;
        sec_r     <= sec_nxt;
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_r <= out_nxt;
    end
  end

endmodule

/* hdl/tda_checker.sv */
// Port-level assertions for the time of day adjust block and their bind.
`include "time_of_day_adjust_defines.svh"

module tda_checker
  import tda_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  logic        fields_ok;
  logic [16:0] total_want;
  logic        load_bad;
  logic        time_zero;

  assign fields_ok  = (out_data.cur_hours < HOURS_PER_DAY)
                   && (out_data.cur_minutes < MINS_PER_HOUR)
                   && (out_data.cur_seconds < SECS_PER_MIN)
                   && (out_data.status <= ST_ZERO_AMOUNT);
  assign total_want = 17'(17'(out_data.cur_hours) * DAY_SECS_PER_HOUR)
                    + 17'(17'(out_data.cur_minutes) * DAY_SECS_PER_MIN)
                    + 17'(out_data.cur_seconds);
  assign load_bad   = (out_data.status == ST_BAD_HOURS)
                   || (out_data.status == ST_BAD_MINUTES)
                   || (out_data.status == ST_BAD_SECONDS);
  assign time_zero  = (out_data.cur_hours == '0) && (out_data.cur_minutes == '0)
                   && (out_data.cur_seconds == '0);

  `TDA_ASSERT_NOW(a_out_range, out_valid, fields_ok, "result beat has a field out of range")
  `TDA_ASSERT_NOW(a_day_total, out_valid, out_data.day_seconds == total_want, "bad day total")
  `TDA_ASSERT_NOW(a_bad_load_clears, out_valid && load_bad, time_zero, "bad load kept time")
  `TDA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "out moved")
  `TDA_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(in_data), "in moved")

endmodule

bind time_of_day_adjust tda_checker u_checker (.*);
